### rtl/core/sost_pkg.sv
package sost_pkg;

	// Item function codes.
	typedef enum logic [1:0] {
		FUNC_LOAD      = 2'd0,
		FUNC_PLAIN     = 2'd1,
		FUNC_TRANSPOSE = 2'd2,
		FUNC_TO_FRONT  = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_FIN
	} state_t;

	localparam int WordW = 32;
	localparam int IndexW = 4;
	localparam int CountW = 5;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic              found;
		logic [IndexW-1:0] position;
	} result_t;

endpackage

### rtl/core/sost_ram.sv
module sost_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sost_ctrl.sv
module sost_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW = $clog2(DEPTH),
	parameter int LW = (AW > 5) ? AW + 1 : 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [LW-1:0]               limit,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [sost_pkg::IndexW-1:0] index,
	input  logic [sost_pkg::WordW-1:0]  value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output sost_pkg::result_t           res,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output logic [sost_pkg::WordW-1:0]  wdata,
	output logic [AW-1:0]               raddr,
	input  logic [sost_pkg::WordW-1:0]  rdata
);

	sost_pkg::state_t state_q, state_d;
	sost_pkg::func_t  func_q;
	logic [sost_pkg::WordW-1:0]  key_q;
	logic [sost_pkg::IndexW-1:0] idx_q;
	logic [sost_pkg::WordW-1:0]  prev_q;
	logic [sost_pkg::WordW-1:0]  front_q;
	logic [LW-1:0]               rd_q;
	logic [LW-1:0]               pos_s1;
	logic                        rvld_s1;
	logic [LW-1:0]               hit_pos_q;
	logic                        found_q;
	logic                        accept;
	logic                        issue;
	logic                        hit;
	logic                        last;
	logic [LW-1:0]               idx_ext;

	assign accept  = in_valid && in_ready;
	assign issue   = (state_q == sost_pkg::ST_SCAN) && (rd_q < limit);
	assign hit     = rvld_s1 && (rdata == key_q);
	assign last    = rvld_s1 && (pos_s1 == limit - LW'(1));
	assign idx_ext = {{(LW-sost_pkg::IndexW){1'b0}}, idx_q};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sost_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sost_pkg::func_t'(func) == sost_pkg::FUNC_LOAD) begin
						state_d = sost_pkg::ST_LOAD;
					end else if (limit == '0) begin
						state_d = sost_pkg::ST_FIN;
					end else begin
						state_d = sost_pkg::ST_SCAN;
					end
				end
			end
			sost_pkg::ST_LOAD: begin
				state_d = sost_pkg::ST_FIN;
			end
			sost_pkg::ST_SCAN: begin
				if (hit) begin
					if (func_q != sost_pkg::FUNC_PLAIN && pos_s1 != '0) begin
						state_d = sost_pkg::ST_SWAP_A;
					end else begin
						state_d = sost_pkg::ST_FIN;
					end
				end else if (last) begin
					state_d = sost_pkg::ST_FIN;
				end
			end
			sost_pkg::ST_SWAP_A: begin
				state_d = sost_pkg::ST_SWAP_B;
			end
			sost_pkg::ST_SWAP_B: begin
				state_d = sost_pkg::ST_FIN;
			end
			sost_pkg::ST_FIN: begin
				if (res_ready) begin
					state_d = sost_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sost_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: memory port drive and handshakes.
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		we        = 1'b0;
		waddr     = idx_ext[AW-1:0];
		wdata     = key_q;
		raddr     = rd_q[AW-1:0];
		res.found    = (func_q == sost_pkg::FUNC_LOAD) ? 1'b1 : found_q;
		res.position = (func_q == sost_pkg::FUNC_LOAD) ? idx_q
			: hit_pos_q[sost_pkg::IndexW-1:0];
		unique case (state_q)
			sost_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			sost_pkg::ST_LOAD: begin
				we = (idx_ext < LW'(DEPTH));
			end
			sost_pkg::ST_SCAN: begin
				we = 1'b0;
			end
			sost_pkg::ST_SWAP_A: begin
				// The matching entry takes the word before it, or the front word.
				we    = 1'b1;
				waddr = hit_pos_q[AW-1:0];
				wdata = (func_q == sost_pkg::FUNC_TRANSPOSE) ? prev_q : front_q;
			end
			sost_pkg::ST_SWAP_B: begin
				// The key moves one place up, or to the front.
				we    = 1'b1;
				waddr = (func_q == sost_pkg::FUNC_TRANSPOSE)
					? hit_pos_q[AW-1:0] - AW'(1) : '0;
				wdata = key_q;
			end
			sost_pkg::ST_FIN: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sost_pkg::ST_IDLE;
			rvld_s1   <= 1'b0;
			found_q   <= 1'b0;
			rd_q      <= '0;
			hit_pos_q <= '0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= issue;
			if (accept) begin
				found_q   <= 1'b0;
				hit_pos_q <= '0;
				rd_q      <= '0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + LW'(1);
				end
				if (state_q == sost_pkg::ST_SCAN && hit) begin
					found_q   <= 1'b1;
					hit_pos_q <= pos_s1;
				end
			end
		end
	end

	// Item payload and scan data registers. The word before the match is
	// kept, so the matching word itself must not overwrite it.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= sost_pkg::func_t'(func);
			key_q  <= value;
			idx_q  <= index;
		end
		pos_s1 <= rd_q;
		if (state_q == sost_pkg::ST_SCAN && rvld_s1) begin
			if (!hit) begin
				prev_q <= rdata;
			end
			if (pos_s1 == '0) begin
				front_q <= rdata;
			end
		end
	end

	// The table is never written while a scan reads it.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sost_pkg::ST_SCAN) |-> !we)
		else $error("table written during scan");

	// A reported search match lies inside the examined range.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found_q && func_q != sost_pkg::FUNC_LOAD) |-> (hit_pos_q < limit))
		else $error("match position outside search range");

	// Only one item is in process: no input transfer right after another.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while an item is in process");

endmodule

### rtl/core/self_organizing_search_table_top.sv
// Self-organizing search table: a table of DEPTH signed 32-bit words held in a
// single synchronous RAM. A load item writes one entry and returns found = 1
// with the index echoed; a search scans entries 0 up to min(entries_in_use,
// DEPTH) - 1, one RAM read per cycle, and reports the first match position or
// found = 0 with position 0. Transposition searches swap the match with the
// entry before it and move-to-front searches swap it with entry 0; a match at
// position 0 is never moved. A load writes its entry in the LOAD state; a
// search reads entries in the SCAN state until a match or the limit, and a
// swap writes back in the SWAP_A and SWAP_B states. The single RAM port pair
// sets this: the scan reads one entry per cycle and the swap writes its two
// entries one after the other. One item is processed at a time, but a finished
// result waits in an output register so the next item can be taken meanwhile.
// Entries must be loaded before a search reaches them. The user must write
// entries_in_use only while the block is idle; the block does not enforce it.
module self_organizing_search_table_top #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sost_pkg::CountW-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [sost_pkg::IndexW-1:0]      index,
	input  logic signed [sost_pkg::WordW-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [sost_pkg::IndexW-1:0]      position
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = (AW > 5) ? AW + 1 : 6;

	logic [sost_pkg::CountW-1:0] eiu_q;
	logic [LW-1:0]               eiu_ext;
	logic [LW-1:0]               limit;
	logic                        res_valid;
	logic                        res_ready;
	sost_pkg::result_t           res;
	sost_pkg::result_t           out_q;
	logic                        out_valid_q;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [sost_pkg::WordW-1:0]  wdata;
	logic [AW-1:0]               raddr;
	logic [sost_pkg::WordW-1:0]  rdata;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= '0;
		end else if (cfg_we) begin
			eiu_q <= cfg_wdata;
		end
	end

	// The search range is clamped to the table depth.
	assign eiu_ext = {{(LW-sost_pkg::CountW){1'b0}}, eiu_q};
	assign limit   = (eiu_ext > LW'(DEPTH)) ? LW'(DEPTH) : eiu_ext;

	// Output register: holds a result until its transfer.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_q.found;
	assign position  = out_q.position;

	sost_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.LW   (LW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.index    (index),
		.value    (value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	sost_ram #(
		.WIDTH(sost_pkg::WordW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule
